// ===== design/wep_pkg.sv =====
// shared types, codes and constants of the weighted entry picker
package wep_pkg;

  localparam int MAX_ENTRIES_DEF = 256;
  localparam int WEIGHT_BITS_DEF = 32;

  localparam int CMD_W    = 2;
  localparam int IDX_IN_W = 8;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 3;
  localparam int TOTAL_W  = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_PICK   = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_BAD_IDX  = 3'd3,
    ST_ZERO_TOT = 3'd4
  } status_t;

  // where the store read address comes from
  typedef enum logic [1:0] {
    RD_IDX,
    RD_ZERO,
    RD_SCAN
  } rd_src_t;

  // where the reported index and id come from
  typedef enum logic [2:0] {
    SRC_ZERO,
    SRC_APPEND,
    SRC_UPDATE,
    SRC_FIRST,
    SRC_PICK
  } res_src_t;

  typedef struct packed {
    logic     load_in;
    logic     rd_en;
    rd_src_t  rd_src;
    logic     app_wr;
    logic     upd_wr;
    logic     mul_lo;
    logic     mul_hi;
    logic     sel_ld;
    logic     scan_init;
    logic     scan_en;
    logic     res_ld;
    status_t  res_status;
    res_src_t res_src;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic full;
    logic idx_bad;
    logic cnt_zero;
    logic cnt_one;
    logic sum_zero;
    logic hit;
    logic scan_done;
  } dp_stat_t;

endpackage

// ===== design/wep_ctrl.sv =====
// controller state machine of the weighted entry picker
module wep_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  wep_pkg::dp_stat_t dp_stat,
  output wep_pkg::dp_cmd_t  dp_cmd
);
  import wep_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_UPD,
    S_MUL_LO,
    S_MUL_HI,
    S_SEL,
    S_SCAN,
    S_RESP
  } state_t;

  state_t   state_r, state_nxt;
  logic     out_valid_r, out_valid_nxt;
  status_t  res_status_r, res_status_nxt;
  res_src_t res_src_r, res_src_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    res_status_nxt = res_status_r;
    res_src_nxt    = res_src_r;
    dp_cmd         = '0;
    dp_cmd.rd_src     = RD_SCAN;
    dp_cmd.res_status = res_status_r;
    dp_cmd.res_src    = res_src_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          dp_cmd.load_in = 1'b1;
          state_nxt      = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt      = S_RESP;
        res_status_nxt = ST_OK;
        res_src_nxt    = SRC_ZERO;
        case (dp_stat.cmd)
          CMD_APPEND: begin
            if (dp_stat.full) begin
              res_status_nxt = ST_FULL;
            end else begin
              dp_cmd.app_wr = 1'b1;
              res_src_nxt   = SRC_APPEND;
            end
          end
          CMD_UPDATE: begin
            if (dp_stat.idx_bad) begin
              res_status_nxt = ST_BAD_IDX;
            end else begin
              dp_cmd.rd_en  = 1'b1;
              dp_cmd.rd_src = RD_IDX;
              state_nxt     = S_UPD;
            end
          end
          CMD_PICK: begin
            if (dp_stat.cnt_zero) begin
              res_status_nxt = ST_EMPTY;
            end else if (dp_stat.cnt_one) begin
              dp_cmd.rd_en  = 1'b1;
              dp_cmd.rd_src = RD_ZERO;
              res_src_nxt   = SRC_FIRST;
            end else if (dp_stat.sum_zero) begin
              res_status_nxt = ST_ZERO_TOT;
            end else begin
              state_nxt = S_MUL_LO;
            end
          end
          default: begin
            res_status_nxt = ST_OK;
          end
        endcase
      end
      S_UPD: begin
        dp_cmd.upd_wr = 1'b1;
        res_src_nxt   = SRC_UPDATE;
        state_nxt     = S_RESP;
      end
      S_MUL_LO: begin
        dp_cmd.mul_lo = 1'b1;
        state_nxt     = S_MUL_HI;
      end
      S_MUL_HI: begin
        dp_cmd.mul_hi = 1'b1;
        state_nxt     = S_SEL;
      end
      S_SEL: begin
        dp_cmd.sel_ld    = 1'b1;
        dp_cmd.scan_init = 1'b1;
        state_nxt        = S_SCAN;
      end
      S_SCAN: begin
        dp_cmd.scan_en = 1'b1;
        if (dp_stat.hit) begin
          res_src_nxt = SRC_PICK;
          state_nxt   = S_RESP;
        end else if (dp_stat.scan_done) begin
          res_status_nxt = ST_ZERO_TOT;
          res_src_nxt    = SRC_ZERO;
          state_nxt      = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          dp_cmd.res_ld = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = dp_cmd.res_ld | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      res_status_r <= ST_OK;
      res_src_r    <= SRC_ZERO;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      res_status_r <= res_status_nxt;
      res_src_r    <= res_src_nxt;
    end
  end

endmodule

// ===== design/wep_datapath.sv =====
// entry stores, weight sum, selector multiply and scan datapath
module wep_datapath #(
  parameter int MAX_ENTRIES = wep_pkg::MAX_ENTRIES_DEF,
  parameter int WEIGHT_BITS = wep_pkg::WEIGHT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [wep_pkg::CMD_W-1:0]       in_command,
  input  logic [wep_pkg::IDX_IN_W-1:0]    in_entry_index,
  input  logic [wep_pkg::DATA_W-1:0]      in_weight,
  input  logic [wep_pkg::DATA_W-1:0]      in_entry_id,
  input  logic [wep_pkg::DATA_W-1:0]      in_rand_fraction,
  input  wep_pkg::dp_cmd_t                dp_cmd,
  output wep_pkg::dp_stat_t               dp_stat,
  output logic [wep_pkg::STATUS_W-1:0]    out_status,
  output logic [wep_pkg::IDX_IN_W-1:0]    out_picked_index,
  output logic [wep_pkg::DATA_W-1:0]      out_picked_id,
  output logic [wep_pkg::TOTAL_W-1:0]     out_total_weight
);
  import wep_pkg::*;

  localparam int KW     = (WEIGHT_BITS < DATA_W) ? WEIGHT_BITS : DATA_W;
  localparam int IDX_W  = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int SUM_W  = KW + CNT_W;
  localparam int PAD_W  = (SUM_W > DATA_W) ? SUM_W : DATA_W + 1;
  localparam int HI_W   = PAD_W - DATA_W;
  localparam int PH_W   = DATA_W + HI_W;
  localparam int CMP_W  = CNT_W + IDX_IN_W;
  localparam int EXT_W  = (SUM_W > TOTAL_W) ? SUM_W : TOTAL_W;

  // latched request
  logic [CMD_W-1:0]    cmd_r;
  logic [IDX_IN_W-1:0] idx_r;
  logic [KW-1:0]       w_r;
  logic [DATA_W-1:0]   id_r;
  logic [DATA_W-1:0]   rnd_r;

  // table state
  logic [KW-1:0]     wmem [MAX_ENTRIES];
  logic [DATA_W-1:0] imem [MAX_ENTRIES];
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [KW-1:0]     rd_w_q;
  logic [DATA_W-1:0] rd_id_q;

  // selector and scan
  logic [2*DATA_W-1:0] prod_lo_r;
  logic [PH_W-1:0]     prod_hi_r;
  logic [SUM_W-1:0]    sel_r;
  logic [SUM_W-1:0]    acc_r, acc_nxt;
  logic [CNT_W-1:0]    scan_addr_r;
  logic [IDX_W-1:0]    scan_idx_r;
  logic                scan_vld_r;
  logic [IDX_W-1:0]    hit_idx_r;
  logic [DATA_W-1:0]   hit_id_r;

  logic [CMP_W-1:0]  idx_wide;
  logic [IDX_W-1:0]  idx_addr;
  logic [IDX_W-1:0]  app_addr;
  logic [IDX_W-1:0]  rd_addr;
  logic              rd_en;
  logic              scan_issue;
  logic              hit;
  logic [PAD_W-1:0]  tot_pad;
  logic [EXT_W-1:0]  sum_ext;

  // result registers
  logic [STATUS_W-1:0] res_status_r;
  logic [IDX_IN_W-1:0] res_idx_r;
  logic [DATA_W-1:0]   res_id_r;
  logic [TOTAL_W-1:0]  res_tot_r;
  logic [IDX_IN_W-1:0] res_idx_nxt;
  logic [DATA_W-1:0]   res_id_nxt;
  logic [TOTAL_W-1:0]  res_tot_nxt;

  assign idx_wide = CMP_W'(idx_r);
  assign idx_addr = IDX_W'(idx_wide);
  assign app_addr = IDX_W'(count_r);
  assign tot_pad  = PAD_W'(sum_r);

  assign scan_issue = dp_cmd.scan_en && (scan_addr_r < count_r);
  assign rd_en      = dp_cmd.rd_en || scan_issue;
  assign acc_nxt    = acc_r + SUM_W'(rd_w_q);
  assign hit        = scan_vld_r && (sel_r < acc_nxt);

  always_comb begin
    case (dp_cmd.rd_src)
      RD_IDX:  rd_addr = idx_addr;
      RD_ZERO: rd_addr = '0;
      default: rd_addr = IDX_W'(scan_addr_r);
    endcase
  end

  always_comb begin
    dp_stat.cmd       = cmd_t'(cmd_r);
    dp_stat.full      = (count_r == CNT_W'(MAX_ENTRIES));
    dp_stat.idx_bad   = (idx_wide >= CMP_W'(count_r));
    dp_stat.cnt_zero  = (count_r == '0);
    dp_stat.cnt_one   = (count_r == CNT_W'(1));
    dp_stat.sum_zero  = (sum_r == '0);
    dp_stat.hit       = hit;
    dp_stat.scan_done = !scan_vld_r && (scan_addr_r >= count_r);
  end

  always_comb begin
    count_nxt = count_r;
    sum_nxt   = sum_r;
    if (dp_cmd.app_wr) begin
      count_nxt = count_r + CNT_W'(1);
      sum_nxt   = sum_r + SUM_W'(w_r);
    end else if (dp_cmd.upd_wr) begin
      sum_nxt = sum_r - SUM_W'(rd_w_q) + SUM_W'(w_r);
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load_in) begin
      cmd_r <= in_command;
      idx_r <= in_entry_index;
      w_r   <= in_weight[KW-1:0];
      id_r  <= in_entry_id;
      rnd_r <= in_rand_fraction;
    end
  end

  // entry stores, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (dp_cmd.app_wr) begin
      wmem[app_addr] <= w_r;
      imem[app_addr] <= id_r;
    end else if (dp_cmd.upd_wr) begin
      wmem[idx_addr] <= w_r;
    end
    if (rd_en) begin
      rd_w_q  <= wmem[rd_addr];
      rd_id_q <= imem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      sum_r      <= '0;
      scan_vld_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      if (dp_cmd.scan_init) begin
        scan_vld_r <= 1'b0;
      end else if (dp_cmd.scan_en) begin
        scan_vld_r <= scan_issue;
      end
    end
  end

  // selector = floor(rand * total / 2^32), split into two partial products
  always_ff @(posedge clk) begin
    if (dp_cmd.mul_lo) begin
      prod_lo_r <= (2*DATA_W)'(rnd_r) * (2*DATA_W)'(tot_pad[DATA_W-1:0]);
    end
    if (dp_cmd.mul_hi) begin
      prod_hi_r <= PH_W'(rnd_r) * PH_W'(tot_pad[PAD_W-1:DATA_W]);
    end
    if (dp_cmd.sel_ld) begin
      sel_r <= SUM_W'(prod_hi_r + PH_W'(prod_lo_r[2*DATA_W-1:DATA_W]));
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.scan_init) begin
      scan_addr_r <= '0;
      acc_r       <= '0;
    end else if (dp_cmd.scan_en) begin
      if (scan_issue) begin
        scan_addr_r <= scan_addr_r + CNT_W'(1);
        scan_idx_r  <= IDX_W'(scan_addr_r);
      end
      if (scan_vld_r) begin
        acc_r <= acc_nxt;
      end
      if (hit) begin
        hit_idx_r <= scan_idx_r;
        hit_id_r  <= rd_id_q;
      end
    end
  end

  assign sum_ext = EXT_W'(sum_r);

  always_comb begin
    case (dp_cmd.res_src)
      SRC_APPEND: begin
        res_idx_nxt = IDX_IN_W'(count_r - CNT_W'(1));
        res_id_nxt  = id_r;
      end
      SRC_UPDATE: begin
        res_idx_nxt = idx_r;
        res_id_nxt  = rd_id_q;
      end
      SRC_FIRST: begin
        res_idx_nxt = '0;
        res_id_nxt  = rd_id_q;
      end
      SRC_PICK: begin
        res_idx_nxt = IDX_IN_W'(hit_idx_r);
        res_id_nxt  = hit_id_r;
      end
      default: begin
        res_idx_nxt = '0;
        res_id_nxt  = '0;
      end
    endcase
    if (sum_ext > EXT_W'({TOTAL_W{1'b1}})) begin
      res_tot_nxt = '1;
    end else begin
      res_tot_nxt = sum_ext[TOTAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.res_ld) begin
      res_status_r <= dp_cmd.res_status;
      res_idx_r    <= res_idx_nxt;
      res_id_r     <= res_id_nxt;
      res_tot_r    <= res_tot_nxt;
    end
  end

  assign out_status       = res_status_r;
  assign out_picked_index = res_idx_r;
  assign out_picked_id    = res_id_r;
  assign out_total_weight = res_tot_r;

endmodule

// ===== design/weighted_entry_picker_top.sv =====
// top level of the weighted entry picker
//
//  channel | ports                                   | moves
//  --------+-----------------------------------------+--------------------------
//  in      | in_valid/in_ready, in_command ...       | one request to the table
//  out     | out_valid/out_ready, out_status ...     | one result per request
//
// append, bad update, empty or single-entry pick: decode, then respond
// update of a valid index: read old weight, then write
// weighted pick: a scan through the weight store of the live entries,
//   one registered store read per cycle, after two partial-product multiplies
// reset (rst_n low, synchronous) empties the table and drops any pending result
// a result waits in the output register while the next request is accepted;
//   that request's result is held back until the output register is free
module weighted_entry_picker_top #(
  parameter int MAX_ENTRIES = wep_pkg::MAX_ENTRIES_DEF,
  parameter int WEIGHT_BITS = wep_pkg::WEIGHT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [wep_pkg::CMD_W-1:0]     in_command,
  input  logic [wep_pkg::IDX_IN_W-1:0]  in_entry_index,
  input  logic [wep_pkg::DATA_W-1:0]    in_weight,
  input  logic [wep_pkg::DATA_W-1:0]    in_entry_id,
  input  logic [wep_pkg::DATA_W-1:0]    in_rand_fraction,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [wep_pkg::STATUS_W-1:0]  out_status,
  output logic [wep_pkg::IDX_IN_W-1:0]  out_picked_index,
  output logic [wep_pkg::DATA_W-1:0]    out_picked_id,
  output logic [wep_pkg::TOTAL_W-1:0]   out_total_weight
);
  import wep_pkg::*;

  // command and status between controller and datapath
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // sequencing of each request, output valid
  wep_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_stat   (dp_stat),
    .dp_cmd    (dp_cmd)
  );

  // stores, running sum, selector and scan, result registers
  wep_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_command       (in_command),
    .in_entry_index   (in_entry_index),
    .in_weight        (in_weight),
    .in_entry_id      (in_entry_id),
    .in_rand_fraction (in_rand_fraction),
    .dp_cmd           (dp_cmd),
    .dp_stat          (dp_stat),
    .out_status       (out_status),
    .out_picked_index (out_picked_index),
    .out_picked_id    (out_picked_id),
    .out_total_weight (out_total_weight)
  );

endmodule

// ===== design/wep_checker.sv =====
// port-level checks of the weighted entry picker and their bind
module wep_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [wep_pkg::STATUS_W-1:0]  out_status,
  input logic [wep_pkg::IDX_IN_W-1:0]  out_picked_index,
  input logic [wep_pkg::DATA_W-1:0]    out_picked_id,
  input logic [wep_pkg::TOTAL_W-1:0]   out_total_weight
);
  import wep_pkg::*;

  // a stalled result keeps its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_picked_index) && $stable(out_picked_id) && $stable(out_total_weight))
    else $error("stalled result changed");

  // reset drops any pending result
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // one request at a time: ready drops after an accept
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // only ok results name an entry
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |->
      (out_picked_index == '0) && (out_picked_id == '0))
    else $error("error result carries an entry");

  // status code within its defined set
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ST_ZERO_TOT))
    else $error("undefined status code");

endmodule

bind weighted_entry_picker_top wep_checker u_wep_checker (.*);

// ===== dv/tb.sv =====
// self-checking testbench for the weighted entry picker top level
`timescale 1ns / 100ps

module tb;
  import wep_pkg::*;

  localparam int MAX_ENTRIES = MAX_ENTRIES_DEF;
  localparam int WEIGHT_BITS = WEIGHT_BITS_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [TOTAL_W-1:0] TOTAL_CAP = {TOTAL_W{1'b1}};
  localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};

  // stimulus plan
  localparam int RANDOM_ITEMS = 1030;
  localparam int HOLD_AT      = 300;   // receiver holds off from here
  localparam int HOLD_CYCLES  = 400;
  localparam int PAUSE_AT     = 600;   // sender drains the block here
  localparam int QUIET_AT     = 880;   // no idling on either side from here
  // a full-table pick scans every entry; leave room after the last result
  localparam int TAIL_CYCLES  = MAX_ENTRIES + 48;
  // slowest run: ~1050 requests, each a full-table pick with stall and gap, plus hold-off, x4
  localparam int CYCLE_LIMIT  = 1_500_000;

  // one request as driven on the in_ ports
  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [IDX_IN_W-1:0] idx;
    logic [DATA_W-1:0]   weight;
    logic [DATA_W-1:0]   id;
    logic [DATA_W-1:0]   frac;
  } request_t;

  // one result as seen on the out_ ports
  typedef struct packed {
    status_t             status;
    logic [IDX_IN_W-1:0] index;
    logic [DATA_W-1:0]   id;
    logic [TOTAL_W-1:0]  total;
  } outcome_t;

  // table mirror, pick arithmetic and the queue of outcomes still owed
  class pick_scoreboard;
    logic [WEIGHT_BITS-1:0] weight_tbl[MAX_ENTRIES];
    logic [DATA_W-1:0]      id_tbl[MAX_ENTRIES];
    int unsigned            n_entries = 0;
    logic [63:0]            exact_sum = '0;
    outcome_t               owed_outcomes[$];
    int                     fail_count = 0;
    int                     cmd_tally[4] = '{default: 0};
    int                     status_tally[5] = '{default: 0};

    function int pending();
      return owed_outcomes.size();
    endfunction

    // work out the outcome of an accepted request and update the mirror
    function void note_request(request_t rq);
      outcome_t    o;
      logic [63:0] sel;
      logic [63:0] acc;
      logic [63:0] hi_part;
      logic [63:0] lo_part;
      bit          found;
      o.status = ST_OK;
      o.index  = '0;
      o.id     = '0;
      case (rq.cmd)
        CMD_APPEND: begin
          if (n_entries >= MAX_ENTRIES) begin
            o.status = ST_FULL;
          end else begin
            weight_tbl[n_entries] = rq.weight[WEIGHT_BITS-1:0];
            id_tbl[n_entries]     = rq.id;
            exact_sum             = exact_sum + 64'(rq.weight[WEIGHT_BITS-1:0]);
            o.index               = IDX_IN_W'(n_entries);
            o.id                  = rq.id;
            n_entries++;
          end
        end
        CMD_UPDATE: begin
          if (rq.idx >= n_entries) begin
            o.status = ST_BAD_IDX;
          end else begin
            exact_sum = exact_sum - 64'(weight_tbl[rq.idx])
                        + 64'(rq.weight[WEIGHT_BITS-1:0]);
            weight_tbl[rq.idx] = rq.weight[WEIGHT_BITS-1:0];
            o.index = rq.idx;
            o.id    = id_tbl[rq.idx];
          end
        end
        CMD_PICK: begin
          if (n_entries == 0) begin
            o.status = ST_EMPTY;
          end else if (n_entries == 1) begin
            o.id = id_tbl[0];
          end else if (exact_sum == 0) begin
            o.status = ST_ZERO_TOT;
          end else begin
            // selector = floor(frac * total / 2^32), split to stay in 64 bits
            hi_part = 64'(rq.frac) * 64'(exact_sum[63:32]);
            lo_part = 64'(rq.frac) * 64'(exact_sum[31:0]);
            sel     = hi_part + (lo_part >> 32);
            acc     = '0;
            found   = 1'b0;
            for (int k = 0; k < n_entries; k++) begin
              if (!found) begin
                acc = acc + 64'(weight_tbl[k]);
                if (sel < acc) begin
                  found   = 1'b1;
                  o.index = IDX_IN_W'(k);
                  o.id    = id_tbl[k];
                end
              end
            end
            if (!found) o.status = ST_ZERO_TOT;
          end
        end
        default: ;
      endcase
      o.total = (exact_sum > 64'(TOTAL_CAP)) ? TOTAL_CAP : exact_sum[TOTAL_W-1:0];
      cmd_tally[rq.cmd]++;
      status_tally[o.status]++;
      owed_outcomes.insert(owed_outcomes.size(), o);
    endfunction

    // compare one accepted result with the oldest outcome owed
    function void check_result(logic [STATUS_W-1:0] st, logic [IDX_IN_W-1:0] ix,
                               logic [DATA_W-1:0] id, logic [TOTAL_W-1:0] tot);
      outcome_t o;
      if (owed_outcomes.size() == 0) begin
        $error("result with no request outstanding: status %0d index %0d", st, ix);
        fail_count++;
        return;
      end
      o = owed_outcomes.pop_front();
      if (st !== o.status) begin
        $error("status: expected %0d, actual %0d", o.status, st);
        fail_count++;
      end
      if (ix !== o.index) begin
        $error("picked_index: expected %0d, actual %0d", o.index, ix);
        fail_count++;
      end
      if (id !== o.id) begin
        $error("picked_id: expected 0x%08h, actual 0x%08h", o.id, id);
        fail_count++;
      end
      if (tot !== o.total) begin
        $error("total_weight: expected 0x%010h, actual 0x%010h", o.total, tot);
        fail_count++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [CMD_W-1:0]    in_command;
  logic [IDX_IN_W-1:0] in_entry_index;
  logic [DATA_W-1:0]   in_weight;
  logic [DATA_W-1:0]   in_entry_id;
  logic [DATA_W-1:0]   in_rand_fraction;
  logic                out_valid;
  logic                out_ready;
  logic [STATUS_W-1:0] out_status;
  logic [IDX_IN_W-1:0] out_picked_index;
  logic [DATA_W-1:0]   out_picked_id;
  logic [TOTAL_W-1:0]  out_total_weight;

  pick_scoreboard sb = new();
  bit             idle_on;    // random idle bursts enabled on both sides
  bit             hold_req;   // ask the receiver for one long hold-off
  int             cycle_count = 0;

  weighted_entry_picker_top #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .WEIGHT_BITS(WEIGHT_BITS)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_entry_index  (in_entry_index),
    .in_weight       (in_weight),
    .in_entry_id     (in_entry_id),
    .in_rand_fraction(in_rand_fraction),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_picked_index(out_picked_index),
    .out_picked_id   (out_picked_id),
    .out_total_weight(out_total_weight)
  );

  // 10 ns clock
  always #5 clk = ~clk;

  // watchdog against a hung handshake
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               sb.pending());
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: ready driven at the falling edge, results taken at the rising edge
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        // long hold-off so the block fills and stalls its request side
        out_ready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        // burst of stalled cycles, this one included
        out_ready  = 1'b0;
        stall_left = $urandom_range(0, 6);
      end else begin
        out_ready = 1'b1;
      end
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        sb.check_result(out_status, out_picked_index, out_picked_id, out_total_weight);
      // hold request is written at falling edges, so read it here
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
    end
  end

  function automatic request_t make_req(logic [CMD_W-1:0] cmd, logic [IDX_IN_W-1:0] idx,
                                        logic [DATA_W-1:0] w, logic [DATA_W-1:0] id,
                                        logic [DATA_W-1:0] frac);
    request_t rq;
    rq.cmd    = cmd;
    rq.idx    = idx;
    rq.weight = w;
    rq.id     = id;
    rq.frac   = frac;
    return rq;
  endfunction

  // weights lean on zero and full scale so scans cross zero entries and wide sums
  function automatic logic [DATA_W-1:0] pick_weight();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return ALL_ONES;
      2:       return DATA_W'($urandom_range(1, 255));
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // random request mix: mostly appends, updates of live entries and picks
  function automatic request_t random_request();
    request_t rq;
    int       roll;
    rq.idx    = IDX_IN_W'($urandom);
    rq.weight = DATA_W'($urandom);
    rq.id     = DATA_W'($urandom);
    case ($urandom_range(0, 7))
      0:       rq.frac = '0;
      1:       rq.frac = ALL_ONES;
      default: rq.frac = DATA_W'($urandom);
    endcase
    roll = $urandom_range(0, 99);
    if (roll < 32) begin
      rq.cmd    = CMD_APPEND;
      rq.weight = pick_weight();
    end else if (roll < 56) begin
      rq.cmd    = CMD_UPDATE;
      rq.weight = pick_weight();
      // most updates hit a live entry, the rest land anywhere in the index range
      if (sb.n_entries > 0 && $urandom_range(0, 9) < 7)
        rq.idx = IDX_IN_W'($urandom_range(0, sb.n_entries - 1));
    end else if (roll < 95) begin
      rq.cmd = CMD_PICK;
    end else begin
      rq.cmd = CMD_UNUSED;
    end
    return rq;
  endfunction

  // drive one request from a falling edge and wait until it is accepted
  task automatic send_request(input request_t rq);
    in_valid         = 1'b1;
    in_command       = rq.cmd;
    in_entry_index   = rq.idx;
    in_weight        = rq.weight;
    in_entry_id      = rq.id;
    in_rand_fraction = rq.frac;
    do @(posedge clk); while (!in_ready);
    sb.note_request(rq);
  endtask

  // send, then maybe leave a gap; always returns at a falling edge
  task automatic issue(input request_t rq);
    int gap;
    send_request(rq);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      gap = $urandom_range(1, 7);
      repeat (gap) @(negedge clk);
    end
  endtask

  initial begin
    request_t rq;
    // every input known from time zero
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_command       = '0;
    in_entry_index   = '0;
    in_weight        = '0;
    in_entry_id      = '0;
    in_rand_fraction = '0;
    out_ready        = 1'b0;
    idle_on          = 1'b1;
    hold_req         = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: special cases while the table is still small
    issue(make_req(CMD_PICK,   8'd0,   '0,       '0,       '0));        // empty table
    issue(make_req(CMD_UPDATE, 8'd0,   ALL_ONES, '0,       '0));        // bad index, empty
    issue(make_req(CMD_UPDATE, 8'hFF,  '0,       ALL_ONES, ALL_ONES));  // bad index, top
    issue(make_req(CMD_UNUSED, 8'hFF,  ALL_ONES, ALL_ONES, ALL_ONES));  // unused code
    issue(make_req(CMD_APPEND, 8'hFF,  '0,       ALL_ONES, ALL_ONES));  // zero-weight entry
    issue(make_req(CMD_PICK,   8'd0,   '0,       '0,       ALL_ONES));  // single, zero weight
    issue(make_req(CMD_UPDATE, 8'd0,   ALL_ONES, '0,       '0));        // full-scale weight
    issue(make_req(CMD_PICK,   8'd0,   '0,       '0,       '0));        // single entry
    issue(make_req(CMD_UPDATE, 8'd1,   '0,       '0,       '0));        // index == count
    issue(make_req(CMD_UPDATE, 8'd0,   '0,       '0,       '0));
    issue(make_req(CMD_APPEND, 8'd0,   '0,       '0,       '0));
    issue(make_req(CMD_PICK,   8'd0,   '0,       '0,       32'h8000_0000)); // zero total
    issue(make_req(CMD_APPEND, 8'd0,   ALL_ONES, 32'h1234_5678, '0));
    issue(make_req(CMD_PICK,   8'd0,   '0,       '0,       '0));        // skips zero entries
    issue(make_req(CMD_PICK,   8'd0,   '0,       '0,       ALL_ONES));
    issue(make_req(CMD_APPEND, 8'd0,   32'd1,    32'hA5A5_5A5A, '0));
    issue(make_req(CMD_PICK,   8'd0,   '0,       '0,       ALL_ONES));  // last entry hit
    issue(make_req(CMD_UPDATE, 8'd2,   32'd1,    '0,       '0));
    issue(make_req(CMD_PICK,   8'd0,   '0,       '0,       32'h8000_0000));
    issue(make_req(CMD_UPDATE, 8'd3,   ALL_ONES, '0,       '0));
    issue(make_req(CMD_APPEND, 8'd0,   32'h8000_0000, 32'h0F0F_F0F0, '0));
    issue(make_req(CMD_PICK,   8'd0,   '0,       '0,       32'h7FFF_FFFF));
    issue(make_req(CMD_UNUSED, 8'd0,   '0,       '0,       '0));

    // random part; the table only grows, so it fills up late in the run
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == HOLD_AT) hold_req = 1'b1;
      if (i == PAUSE_AT) begin
        // sender pause until every outstanding result has come back
        in_valid = 1'b0;
        do @(negedge clk); while (sb.pending() != 0);
      end
      if (i == QUIET_AT) idle_on = 1'b0;
      rq = random_request();
      issue(rq);
    end
    in_valid = 1'b0;

    // drain, then watch for stray results
    while (sb.pending() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("%0d requests: %0d append, %0d update, %0d pick, %0d unused code; %0d entries",
             sb.cmd_tally.sum(), sb.cmd_tally[CMD_APPEND], sb.cmd_tally[CMD_UPDATE],
             sb.cmd_tally[CMD_PICK], sb.cmd_tally[CMD_UNUSED], sb.n_entries);
    $display("outcomes: %0d ok, %0d empty, %0d full, %0d bad index, %0d zero total",
             sb.status_tally[ST_OK], sb.status_tally[ST_EMPTY], sb.status_tally[ST_FULL],
             sb.status_tally[ST_BAD_IDX], sb.status_tally[ST_ZERO_TOT]);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== weighted_entry_picker_top.f =====
design/wep_pkg.sv
design/wep_ctrl.sv
design/wep_datapath.sv
design/weighted_entry_picker_top.sv
design/wep_checker.sv
dv/tb.sv
